// File: hdl/arq_pkg.sv
// Shared types and constants for the arcball rotation quaternion block.
// No dependencies; every other file except hdl/arq_intf.sv imports this package.
package arq_pkg;

    // Output fraction bits, Q1.FRAC_BITS
    localparam int FRAC_BITS = 14;

    // Pipeline step counts of the iterative units
    localparam int SQ_STEPS  = 32;   // 64-bit floor square root, one root bit a step
    localparam int FD_STEPS  = 62;   // fraction divide, one quotient bit a step
    localparam int AD_STEPS  = 32;   // axis divide, one quotient bit a step
    localparam int SB2_LEN   = FD_STEPS + SQ_STEPS;

    // Identity real part, reduced to the 16-bit field
    localparam logic [15:0] QONE = 16'(64'd1 << FRAC_BITS);

    // Sideband carried alongside the norm square roots
    typedef struct packed {
        logic                valid;
        logic                zero;
        logic signed [34:0]  d;
        logic [2:0][31:0]    crmag;
        logic [2:0]          crneg;
    } t_sb1;

    // Front end result: sideband plus the two radicands
    typedef struct packed {
        t_sb1        sb;
        logic [63:0] nn;
        logic [63:0] kk;
    } t_front;

    // Sideband carried alongside the half-angle units
    typedef struct packed {
        logic             valid;
        logic             zero;
        logic             opp;
        logic [31:0]      k;
        logic [2:0][31:0] crmag;
        logic [2:0]       crneg;
    } t_sb2;

    // Sideband carried alongside the axis dividers
    typedef struct packed {
        logic        valid;
        logic        zero;
        logic        opp;
        logic [15:0] w;
        logic [2:0]  crneg;
    } t_sb3;

    // One result beat
    typedef struct packed {
        logic [15:0] w;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic        deg;
    } t_quat;

endpackage

// File: hdl/arq_intf.sv
// Stream interfaces for the vector pair input and the quaternion output.
// Depends on nothing; valid/ready handshake, one beat per accepted item.
interface arq_vec_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] start_z;
    logic signed [15:0] current_x;
    logic signed [15:0] current_y;
    logic signed [15:0] current_z;

    modport source (output valid, start_x, start_y, start_z,
                    current_x, current_y, current_z, input ready);
    modport sink   (input valid, start_x, start_y, start_z,
                    current_x, current_y, current_z, output ready);
endinterface

interface arq_quat_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic               degenerate;

    modport source (output valid, quat_w, quat_x, quat_y, quat_z, degenerate,
                    input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, degenerate,
                    output ready);
endinterface

// File: hdl/arq_front.sv
// Front end: input register, normalizing upscale, products, dot, norms, cross.
// Depends on arq_pkg. Six register stages, all advanced by i_en.
module arq_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [15:0] i_s [3],
    input  logic signed [15:0] i_c [3],
    output arq_pkg::t_front    o_front
);
    import arq_pkg::*;

    logic [5:0]         r_vld;
    logic signed [15:0] r_s [3];
    logic signed [15:0] r_c [3];
    logic signed [16:0] r_us [3];
    logic signed [16:0] r_uc [3];
    logic               r_zero2, r_zero3, r_zero4, r_zero5;
    logic signed [33:0] r_pd [3];
    logic signed [33:0] r_pns [3];
    logic signed [33:0] r_pnc [3];
    logic signed [33:0] r_px [6];
    logic signed [34:0] r_d4, r_d5;
    logic [31:0]        r_ns, r_nc;
    logic [31:0]        r_crm4 [3];
    logic [31:0]        r_crm5 [3];
    logic [2:0]         r_crn4, r_crn5;
    logic [63:0]        r_nn;
    logic [63:0]        r_sq [3];
    t_front             r_out;

    logic signed [16:0] n_us [3];
    logic signed [16:0] n_uc [3];
    logic               n_zero;
    logic signed [34:0] n_d;
    logic signed [33:0] n_cr [3];

    function automatic logic [15:0] mag16(input logic signed [15:0] v);
        return v[15] ? 16'(-v) : 16'(v);
    endfunction

    // doublings needed to bring the largest magnitude to at least 2^14
    function automatic logic [3:0] up_shift(input logic [15:0] m);
        logic [3:0] sh;
        sh = 4'd0;
        for (int b = 0; b < 14; b++) begin
            if (m[b]) sh = 4'(14 - b);
        end
        if (m[15] || m[14]) sh = 4'd0;
        return sh;
    endfunction

    function automatic logic [15:0] max3(input logic [15:0] a, b, c);
        logic [15:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    // upscale both vectors, zero-vector detect
    always_comb begin
        logic [3:0] sh_s, sh_c;
        sh_s = up_shift(max3(mag16(r_s[0]), mag16(r_s[1]), mag16(r_s[2])));
        sh_c = up_shift(max3(mag16(r_c[0]), mag16(r_c[1]), mag16(r_c[2])));
        for (int i = 0; i < 3; i++) begin
            n_us[i] = $signed({r_s[i][15], r_s[i]}) <<< sh_s;
            n_uc[i] = $signed({r_c[i][15], r_c[i]}) <<< sh_c;
        end
        n_zero = ((r_s[0] == 16'sd0) && (r_s[1] == 16'sd0) && (r_s[2] == 16'sd0)) ||
                 ((r_c[0] == 16'sd0) && (r_c[1] == 16'sd0) && (r_c[2] == 16'sd0));
    end

    // dot product and cross product sums
    always_comb begin
        n_d = 35'(r_pd[0]) + 35'(r_pd[1]) + 35'(r_pd[2]);
        n_cr[0] = r_px[0] - r_px[1];
        n_cr[1] = r_px[2] - r_px[3];
        n_cr[2] = r_px[4] - r_px[5];
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 1: input beat
            r_s <= i_s;
            r_c <= i_c;
            // stage 2: upscaled vectors
            r_us    <= n_us;
            r_uc    <= n_uc;
            r_zero2 <= n_zero;
            // stage 3: products
            for (int i = 0; i < 3; i++) begin
                r_pd[i]  <= r_us[i] * r_uc[i];
                r_pns[i] <= r_us[i] * r_us[i];
                r_pnc[i] <= r_uc[i] * r_uc[i];
            end
            r_px[0] <= r_us[1] * r_uc[2];
            r_px[1] <= r_us[2] * r_uc[1];
            r_px[2] <= r_us[2] * r_uc[0];
            r_px[3] <= r_us[0] * r_uc[2];
            r_px[4] <= r_us[0] * r_uc[1];
            r_px[5] <= r_us[1] * r_uc[0];
            r_zero3 <= r_zero2;
            // stage 4: sums
            r_d4    <= n_d;
            r_ns    <= 32'(r_pns[0]) + 32'(r_pns[1]) + 32'(r_pns[2]);
            r_nc    <= 32'(r_pnc[0]) + 32'(r_pnc[1]) + 32'(r_pnc[2]);
            for (int i = 0; i < 3; i++) begin
                r_crn4[i] <= n_cr[i][33];
                r_crm4[i] <= n_cr[i][33] ? 32'(-n_cr[i]) : 32'(n_cr[i]);
            end
            r_zero4 <= r_zero3;
            // stage 5: norm product and cross squares
            r_nn    <= 64'(r_ns) * 64'(r_nc);
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= 64'(r_crm4[i]) * 64'(r_crm4[i]);
            end
            r_d5    <= r_d4;
            r_crm5  <= r_crm4;
            r_crn5  <= r_crn4;
            r_zero5 <= r_zero4;
            // stage 6: cross norm squared
            r_out.kk       <= r_sq[0] + r_sq[1] + r_sq[2];
            r_out.nn       <= r_nn;
            r_out.sb.zero  <= r_zero5;
            r_out.sb.d     <= r_d5;
            r_out.sb.crneg <= r_crn5;
            for (int i = 0; i < 3; i++) begin
                r_out.sb.crmag[i] <= r_crm5[i];
            end
        end
    end

    always_comb begin
        o_front          = r_out;
        o_front.sb.valid = r_vld[5];
    end

endmodule

// File: hdl/arq_isqrt.sv
// Pipelined 64-bit floor square root, one root bit per stage.
// Depends on arq_pkg (SQ_STEPS). Every stage advances only while i_en is high.
module arq_isqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_x,
    output logic [31:0] o_root
);
    import arq_pkg::*;

    logic [63:0] r_x    [SQ_STEPS];
    logic [33:0] r_rem  [SQ_STEPS];
    logic [31:0] r_root [SQ_STEPS];

    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_stage
        logic [63:0] x_in;
        logic [33:0] rem_in;
        logic [31:0] root_in;
        logic [35:0] rem_sh;
        logic [35:0] trial;
        logic [33:0] n_rem;
        logic [31:0] n_root;

        if (g == 0) begin : g_first
            assign x_in    = i_x;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign x_in    = r_x[g-1];
            assign rem_in  = r_rem[g-1];
            assign root_in = r_root[g-1];
        end

        // bring down two radicand bits, try root bit one
        always_comb begin
            rem_sh = {rem_in, x_in[63-2*g -: 2]};
            trial  = {2'b00, root_in, 2'b01};
            if (rem_sh >= trial) begin
                n_rem  = 34'(rem_sh - trial);
                n_root = {root_in[30:0], 1'b1};
            end else begin
                n_rem  = rem_sh[33:0];
                n_root = {root_in[30:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[g]    <= x_in;
                r_rem[g]  <= n_rem;
                r_root[g] <= n_root;
            end
        end
    end

    assign o_root = r_root[SQ_STEPS-1];

endmodule

// File: hdl/arq_fdiv.sv
// Pipelined fraction divider: floor(num * 2^62 / den) for num <= den.
// Depends on arq_pkg (FD_STEPS). Every stage advances only while i_en is high.
module arq_fdiv (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [32:0] i_num,
    input  logic [32:0] i_den,
    output logic [62:0] o_q
);
    import arq_pkg::*;

    logic [32:0] r_rem  [FD_STEPS];
    logic [32:0] r_den  [FD_STEPS];
    logic [61:0] r_q    [FD_STEPS];
    logic        r_full [FD_STEPS];

    for (genvar g = 0; g < FD_STEPS; g++) begin : g_stage
        logic [32:0] rem_in;
        logic [32:0] den_in;
        logic [61:0] q_in;
        logic        full_in;
        logic [33:0] rem_sh;
        logic [32:0] n_rem;
        logic [61:0] n_q;

        if (g == 0) begin : g_first
            assign rem_in  = i_num;
            assign den_in  = i_den;
            assign q_in    = '0;
            assign full_in = (i_num >= i_den);
        end else begin : g_next
            assign rem_in  = r_rem[g-1];
            assign den_in  = r_den[g-1];
            assign q_in    = r_q[g-1];
            assign full_in = r_full[g-1];
        end

        // restoring step
        always_comb begin
            rem_sh = {rem_in, 1'b0};
            if (rem_sh >= {1'b0, den_in}) begin
                n_rem = 33'(rem_sh - {1'b0, den_in});
                n_q   = {q_in[60:0], 1'b1};
            end else begin
                n_rem = rem_sh[32:0];
                n_q   = {q_in[60:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_rem;
                r_den[g]  <= den_in;
                r_q[g]    <= n_q;
                r_full[g] <= full_in;
            end
        end
    end

    // a ratio of one is exactly 2^62
    assign o_q = r_full[FD_STEPS-1] ? {1'b1, 62'd0} : {1'b0, r_q[FD_STEPS-1]};

endmodule

// File: hdl/arq_adiv.sv
// Pipelined axis divider: floor(num / den) with a quotient below 2^32.
// Depends on arq_pkg (AD_STEPS). Zero divisor yields zero.
module arq_adiv (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic [31:0] o_q
);
    import arq_pkg::*;

    logic [31:0] r_rem [AD_STEPS];
    logic [31:0] r_lo  [AD_STEPS];
    logic [31:0] r_den [AD_STEPS];
    logic [31:0] r_q   [AD_STEPS];
    logic        r_kz  [AD_STEPS];

    for (genvar g = 0; g < AD_STEPS; g++) begin : g_stage
        logic [31:0] rem_in;
        logic [31:0] lo_in;
        logic [31:0] den_in;
        logic [31:0] q_in;
        logic        kz_in;
        logic [32:0] rem_sh;
        logic [31:0] n_rem;
        logic [31:0] n_q;

        // high half is already below the divisor
        if (g == 0) begin : g_first
            assign rem_in = i_num[63:32];
            assign lo_in  = i_num[31:0];
            assign den_in = i_den;
            assign q_in   = '0;
            assign kz_in  = (i_den == 32'd0);
        end else begin : g_next
            assign rem_in = r_rem[g-1];
            assign lo_in  = r_lo[g-1];
            assign den_in = r_den[g-1];
            assign q_in   = r_q[g-1];
            assign kz_in  = r_kz[g-1];
        end

        always_comb begin
            rem_sh = {rem_in, lo_in[31-g]};
            if (rem_sh >= {1'b0, den_in}) begin
                n_rem = 32'(rem_sh - {1'b0, den_in});
                n_q   = {q_in[30:0], 1'b1};
            end else begin
                n_rem = rem_sh[31:0];
                n_q   = {q_in[30:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= n_rem;
                r_lo[g]  <= lo_in;
                r_den[g] <= den_in;
                r_q[g]   <= n_q;
                r_kz[g]  <= kz_in;
            end
        end
    end

    assign o_q = r_kz[AD_STEPS-1] ? 32'd0 : r_q[AD_STEPS-1];

endmodule

// File: hdl/arcball_rotation_quaternion.sv
// Throughput: one vector pair per cycle while the output buffer is not full; every stage,
// including the square root and divider units (one result bit per stage), takes a new
// beat each cycle.
// A two-beat output buffer holds results; the pipeline halts only while it is full.
// Reset (synchronous, active low) clears all valid bits and the output buffer.
module arcball_rotation_quaternion (
    input  logic        i_clk,
    input  logic        i_rst_n,
    arq_vec_if.sink     i_vec,
    arq_quat_if.source  o_quat
);
    import arq_pkg::*;

    localparam logic [32:0] RND_HALF = 33'(64'd1 << (30 - FRAC_BITS));
    localparam int          RND_SH   = 31 - FRAC_BITS;

    logic               en;
    logic               push, pop;
    logic signed [15:0] in_s [3];
    logic signed [15:0] in_c [3];
    t_front             front;
    logic [31:0]        sq_p, sq_k;
    logic [62:0]        fq_c, fq_s;
    logic [31:0]        hc, hs;
    logic [31:0]        aq [3];
    t_quat              n_quat;
    t_sb2               n_s39;
    logic [32:0]        n_numc, n_nums;

    t_sb1               r_sb1 [SQ_STEPS];
    t_sb2               r_s39;
    logic [32:0]        r_numc, r_nums, r_den;
    t_sb2               r_sb2 [SB2_LEN];
    t_sb3               r_s134;
    logic [63:0]        r_prod [3];
    logic [31:0]        r_k;
    t_sb3               r_sb3 [AD_STEPS];
    t_quat              r_fifo [2];
    logic               r_wr, r_rd;
    logic [1:0]         r_cnt;

    function automatic logic [15:0] q31_round(input logic [31:0] m);
        logic [32:0] s;
        s = {1'b0, m} + RND_HALF;
        return 16'(s >> RND_SH);
    endfunction

    // pipeline advances unless the output buffer is full
    assign en          = (r_cnt != 2'd2);
    assign i_vec.ready = en;

    assign in_s[0] = i_vec.start_x;
    assign in_s[1] = i_vec.start_y;
    assign in_s[2] = i_vec.start_z;
    assign in_c[0] = i_vec.current_x;
    assign in_c[1] = i_vec.current_y;
    assign in_c[2] = i_vec.current_z;

    arq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_vec.valid),
        .i_s     (in_s),
        .i_c     (in_c),
        .o_front (front)
    );

    // norm product and cross norm roots
    arq_isqrt u_sqrt_p (.i_clk(i_clk), .i_en(en), .i_x(front.nn), .o_root(sq_p));
    arq_isqrt u_sqrt_k (.i_clk(i_clk), .i_en(en), .i_x(front.kk), .o_root(sq_k));

    // clamp dot to [-P, P], form half-angle numerators
    always_comb begin
        logic signed [34:0] pe, dc;
        t_sb1               sb;
        sb = r_sb1[SQ_STEPS-1];
        pe = $signed({3'b000, sq_p});
        if (sb.d > pe) begin
            dc = pe;
        end else if (sb.d < -pe) begin
            dc = -pe;
        end else begin
            dc = sb.d;
        end
        n_numc      = 33'(pe + dc);
        n_nums      = 33'(pe - dc);
        n_s39.valid = sb.valid;
        n_s39.zero  = sb.zero;
        n_s39.opp   = (sb.crmag[0] == 32'd0) && (sb.crmag[1] == 32'd0) &&
                      (sb.crmag[2] == 32'd0) && dc[34];
        n_s39.k     = sq_k;
        n_s39.crmag = sb.crmag;
        n_s39.crneg = sb.crneg;
    end

    arq_fdiv u_fdiv_c (.i_clk(i_clk), .i_en(en), .i_num(r_numc), .i_den(r_den), .o_q(fq_c));
    arq_fdiv u_fdiv_s (.i_clk(i_clk), .i_en(en), .i_num(r_nums), .i_den(r_den), .o_q(fq_s));

    arq_isqrt u_sqrt_c (.i_clk(i_clk), .i_en(en), .i_x({1'b0, fq_c}), .o_root(hc));
    arq_isqrt u_sqrt_s (.i_clk(i_clk), .i_en(en), .i_x({1'b0, fq_s}), .o_root(hs));

    for (genvar i = 0; i < 3; i++) begin : g_axis
        arq_adiv u_adiv (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r_prod[i]),
            .i_den (r_k),
            .o_q   (aq[i])
        );
    end

    // final rounding, sign and special-case select
    always_comb begin
        t_sb3        sb;
        logic [15:0] qm [3];
        sb = r_sb3[AD_STEPS-1];
        for (int i = 0; i < 3; i++) begin
            qm[i] = q31_round(aq[i]);
            qm[i] = sb.crneg[i] ? 16'(-qm[i]) : qm[i];
        end
        if (sb.zero) begin
            n_quat = '{w: QONE, x: 16'd0, y: 16'd0, z: 16'd0, deg: 1'b1};
        end else if (sb.opp) begin
            n_quat = '{w: 16'd0, x: 16'd0, y: 16'd0, z: 16'd0, deg: 1'b1};
        end else begin
            n_quat = '{w: sb.w, x: qm[0], y: qm[1], z: qm[2], deg: 1'b0};
        end
    end

    // sideband lines; reset clears only their valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < SQ_STEPS; j++) r_sb1[j].valid <= 1'b0;
            for (int j = 0; j < SB2_LEN; j++)  r_sb2[j].valid <= 1'b0;
            for (int j = 0; j < AD_STEPS; j++) r_sb3[j].valid <= 1'b0;
            r_s39.valid  <= 1'b0;
            r_s134.valid <= 1'b0;
        end else if (en) begin
            r_sb1[0] <= front.sb;
            for (int j = 1; j < SQ_STEPS; j++) r_sb1[j] <= r_sb1[j-1];
            r_s39 <= n_s39;
            r_sb2[0] <= r_s39;
            for (int j = 1; j < SB2_LEN; j++) r_sb2[j] <= r_sb2[j-1];
            r_s134.valid <= r_sb2[SB2_LEN-1].valid;
            r_s134.zero  <= r_sb2[SB2_LEN-1].zero;
            r_s134.opp   <= r_sb2[SB2_LEN-1].opp;
            r_s134.crneg <= r_sb2[SB2_LEN-1].crneg;
            r_s134.w     <= q31_round(hc);
            r_sb3[0] <= r_s134;
            for (int j = 1; j < AD_STEPS; j++) r_sb3[j] <= r_sb3[j-1];
        end
    end

    // datapath registers between the units
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_numc <= n_numc;
            r_nums <= n_nums;
            r_den  <= {sq_p, 1'b0};
            for (int i = 0; i < 3; i++) begin
                r_prod[i] <= 64'(hs) * 64'(r_sb2[SB2_LEN-1].crmag[i]);
            end
            r_k <= r_sb2[SB2_LEN-1].k;
        end
    end

    // two-beat output buffer
    assign push = en && r_sb3[AD_STEPS-1].valid;
    assign pop  = o_quat.valid && o_quat.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (pop)  r_rd <= ~r_rd;
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_fifo[r_wr] <= n_quat;
    end

    assign o_quat.valid      = (r_cnt != 2'd0);
    assign o_quat.quat_w     = r_fifo[r_rd].w;
    assign o_quat.quat_x     = r_fifo[r_rd].x;
    assign o_quat.quat_y     = r_fifo[r_rd].y;
    assign o_quat.quat_z     = r_fifo[r_rd].z;
    assign o_quat.degenerate = r_fifo[r_rd].deg;

endmodule

// File: hdl/arq_check.sv
// Port-level checker for arcball_rotation_quaternion, attached by bind.
// Depends on arq_pkg (QONE) and the top level's interface ports.
module arq_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_w,
    input logic [15:0] i_x,
    input logic [15:0] i_y,
    input logic [15:0] i_z,
    input logic        i_deg
);
    import arq_pkg::*;

    // nothing is offered right after reset
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_w) && $stable(i_x) && $stable(i_y) &&
            $stable(i_z) && $stable(i_deg))
        else $error("output beat changed while stalled");

    // input back-pressure only when results are waiting
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with no result pending");

    // degenerate results are the identity or all zero
    a_deg_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_deg |->
            (i_x == 16'd0) && (i_y == 16'd0) && (i_z == 16'd0) &&
            ((i_w == 16'd0) || (i_w == QONE)))
        else $error("bad degenerate result");

endmodule

bind arcball_rotation_quaternion arq_check u_arq_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_vec.valid),
    .i_in_ready  (i_vec.ready),
    .i_out_valid (o_quat.valid),
    .i_out_ready (o_quat.ready),
    .i_w         (o_quat.quat_w),
    .i_x         (o_quat.quat_x),
    .i_y         (o_quat.quat_y),
    .i_z         (o_quat.quat_z),
    .i_deg       (o_quat.degenerate)
);
